// File: rtl/se2cay_pkg.sv
// Shared types, constants and result rounding for the SE(2) Cayley unit.
package se2cay_pkg;

  localparam int unsigned NumLanes = 4;
  localparam int unsigned DivSteps = 33;
  localparam int unsigned DvdW     = 100;
  localparam int unsigned SumW     = 67;

  localparam logic [15:0] TolReset = 16'd1;

  localparam logic OpFwd = 1'b0;
  localparam logic OpInv = 1'b1;

  localparam logic [63:0] FourQ32 = 64'd1 << 34;

  // Products stage.
  typedef struct packed {
    logic               op;
    logic signed [31:0] rb;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [32:0] e;
    logic signed [65:0] p0;
    logic signed [65:0] p1;
    logic signed [65:0] p2;
    logic signed [65:0] p3;
  } mul_t;

  // Signed numerators and the common divisor.
  typedef struct packed {
    logic                          op;
    logic [63:0]                   d;
    logic                          flip;
    logic                          sing;
    logic [31:0]                   px;
    logic [31:0]                   py;
    logic [NumLanes-1:0][SumW-1:0] v;
  } sum_t;

  // Shifted dividends in magnitude form.
  typedef struct packed {
    logic [63:0]                   d;
    logic                          sing;
    logic [31:0]                   px;
    logic [31:0]                   py;
    logic [NumLanes-1:0][DvdW-1:0] dvd;
    logic [NumLanes-1:0]           neg;
  } dvd_t;

  typedef struct packed {
    logic [63:0]         r;
    logic [DivSteps-1:0] lo;
    logic                big;
    logic                neg;
  } lane_t;

  typedef struct packed {
    logic [63:0]               d;
    logic                      sing;
    logic [31:0]               px;
    logic [31:0]               py;
    lane_t [NumLanes-1:0]      ln;
  } div_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  // Left shift applied to each lane's magnitude (one extra bit for rounding).
  function automatic logic [5:0] lane_shift(input logic [1:0] lane, input logic op);
    logic [5:0] k;
    k = 6'd0;
    case (lane)
      2'd0:    k = (op == OpInv) ? 6'd18 : 6'd17;
      2'd1:    k = 6'd35;
      default: k = (op == OpInv) ? 6'd1 : 6'd18;
    endcase
    return k;
  endfunction

  // Round half away from zero, then clamp to the signed 32-bit range.
  function automatic sat_t round_sat(input lane_t ln);
    sat_t        res;
    logic [33:0] rs;
    logic [32:0] rnd;
    logic [32:0] negv;
    rs   = {1'b0, ln.lo} + 34'd1;
    rnd  = rs[33:1];
    negv = ~rnd + 33'd1;
    if (ln.neg) begin
      res.ovf = ln.big || (rnd > 33'h080000000);
      res.val = res.ovf ? 32'h80000000 : negv[31:0];
    end else begin
      res.ovf = ln.big || (rnd > 33'h07FFFFFFF);
      res.val = res.ovf ? 32'h7FFFFFFF : rnd[31:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/se2_cayley_map_unit_core.sv
// SE(2) Cayley map and inverse Cayley map, Q16.16, fully pipelined.
// One beat enters per cycle while the output is not stalled, and an accepted
// beat reaches out_valid_o through 38 register stages: multiply, sum and shift, one
// overflow-test stage, the 33-step restoring divider (one quotient bit per
// stage, four lanes sharing one divisor) and the output register.
// A stall on the output freezes every stage, so the input stalls with it.
// The tolerance register should be written only while the pipe is empty.
module se2_cayley_map_unit_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic signed [31:0] rot_a_i,
  input  logic signed [31:0] rot_b_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_a_o,
  output logic signed [31:0] out_b_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic               flag_o
);

  localparam int unsigned NL = se2cay_pkg::NumLanes;
  localparam int unsigned NS = se2cay_pkg::DivSteps;

  logic        adv;
  logic [15:0] tol_q;

  logic                 s1_vld_q, s2_vld_q, s3_vld_q;
  se2cay_pkg::mul_t     s1_d, s1_q;
  se2cay_pkg::sum_t     s2_d, s2_q;
  se2cay_pkg::dvd_t     s3_d, s3_q;
  logic [NS:0]          dv_vld_q;
  se2cay_pkg::div_t     dv_d [NS+1];
  se2cay_pkg::div_t     dv_q [NS+1];

  logic                 out_vld_q;
  logic [31:0]          oa_d, ob_d, ox_d, oy_d;
  logic [31:0]          oa_q, ob_q, ox_q, oy_q;
  logic                 of_d, of_q;

  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= se2cay_pkg::TolReset;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Stage 1: the four products.
  logic signed [32:0] ra_x, e_x;
  logic signed [32:0] ma [NL];
  logic signed [32:0] mb [NL];
  logic               fwd1;

  always_comb begin
    fwd1  = (operation_i == se2cay_pkg::OpFwd);
    ra_x  = {rot_a_i[31], rot_a_i};
    e_x   = ra_x + 33'sd65536;
    ma[0] = fwd1 ? ra_x : {pos_x_i[31], pos_x_i};
    mb[0] = fwd1 ? ra_x : e_x;
    ma[1] = fwd1 ? ra_x : {rot_b_i[31], rot_b_i};
    mb[1] = {pos_y_i[31], pos_y_i};
    ma[2] = fwd1 ? ra_x : {pos_y_i[31], pos_y_i};
    mb[2] = fwd1 ? {pos_x_i[31], pos_x_i} : e_x;
    ma[3] = {rot_b_i[31], rot_b_i};
    mb[3] = {pos_x_i[31], pos_x_i};
    s1_d.op = operation_i;
    s1_d.rb = rot_b_i;
    s1_d.px = pos_x_i;
    s1_d.py = pos_y_i;
    s1_d.e  = e_x;
    s1_d.p0 = ma[0] * mb[0];
    s1_d.p1 = ma[1] * mb[1];
    s1_d.p2 = ma[2] * mb[2];
    s1_d.p3 = ma[3] * mb[3];
  end

  // Stage 2: numerators, divisor and the singular test.
  logic        fwd2;
  logic [32:0] em;
  logic signed [32:0] ra_s2;
  logic signed [66:0] p0x, p1x, p2x, p3x, pxs, pys;

  always_comb begin
    fwd2  = (s1_q.op == se2cay_pkg::OpFwd);
    em    = s1_q.e[32] ? 33'(-s1_q.e) : s1_q.e;
    ra_s2 = s1_q.e - 33'sd65536;
    p0x   = {s1_q.p0[65], s1_q.p0};
    p1x   = {s1_q.p1[65], s1_q.p1};
    p2x   = {s1_q.p2[65], s1_q.p2};
    p3x   = {s1_q.p3[65], s1_q.p3};
    pxs   = {{18{s1_q.px[31]}}, s1_q.px, 17'b0};
    pys   = {{18{s1_q.py[31]}}, s1_q.py, 17'b0};
    s2_d.op   = s1_q.op;
    s2_d.px   = s1_q.px;
    s2_d.py   = s1_q.py;
    s2_d.flip = !fwd2 && s1_q.e[32];
    s2_d.sing = !fwd2 && ((em < {17'b0, tol_q}) || (em == 33'd0));
    if (fwd2) begin
      s2_d.d    = se2cay_pkg::FourQ32 + s1_q.p0[63:0];
      s2_d.v[0] = $signed({3'b0, se2cay_pkg::FourQ32}) - p0x;
      s2_d.v[1] = {{34{ra_s2[32]}}, ra_s2};
      s2_d.v[2] = pxs - p1x;
      s2_d.v[3] = pys + p2x;
    end else begin
      s2_d.d    = {31'b0, em};
      s2_d.v[0] = {{35{s1_q.rb[31]}}, s1_q.rb};
      s2_d.v[1] = '0;
      s2_d.v[2] = p0x + p1x;
      s2_d.v[3] = p2x - p3x;
    end
  end

  // Stage 3: magnitudes, signs and aligned dividends.
  logic [66:0] av [NL];

  always_comb begin
    s3_d.d    = s2_q.d;
    s3_d.sing = s2_q.sing;
    s3_d.px   = s2_q.px;
    s3_d.py   = s2_q.py;
    for (int i = 0; i < NL; i++) begin
      av[i]       = s2_q.v[i][66] ? 67'(-s2_q.v[i]) : s2_q.v[i];
      s3_d.neg[i] = s2_q.v[i][66] ^ s2_q.flip;
      s3_d.dvd[i] = {36'b0, av[i][63:0]} << se2cay_pkg::lane_shift(2'(i), s2_q.op);
    end
  end

  logic [66:0] hi [NL];
  logic [64:0] tr [NS][NL];
  logic        ge [NS][NL];

  always_comb begin
    // Stage 4: overflow test and the initial partial remainder.
    dv_d[0].d    = s3_q.d;
    dv_d[0].sing = s3_q.sing;
    dv_d[0].px   = s3_q.px;
    dv_d[0].py   = s3_q.py;
    for (int i = 0; i < NL; i++) begin
      hi[i]           = s3_q.dvd[i][99:33];
      dv_d[0].ln[i].big = hi[i] >= {3'b0, s3_q.d};
      dv_d[0].ln[i].r   = hi[i][63:0];
      dv_d[0].ln[i].lo  = s3_q.dvd[i][32:0];
      dv_d[0].ln[i].neg = s3_q.neg[i];
    end
    // Divider steps: shift in one dividend bit, retire one quotient bit.
    for (int j = 1; j <= NS; j++) begin
      dv_d[j].d    = dv_q[j-1].d;
      dv_d[j].sing = dv_q[j-1].sing;
      dv_d[j].px   = dv_q[j-1].px;
      dv_d[j].py   = dv_q[j-1].py;
      for (int i = 0; i < NL; i++) begin
        tr[j-1][i] = {dv_q[j-1].ln[i].r, dv_q[j-1].ln[i].lo[NS-1]};
        ge[j-1][i] = tr[j-1][i] >= {1'b0, dv_q[j-1].d};
        dv_d[j].ln[i].r   = ge[j-1][i] ? 64'(tr[j-1][i] - {1'b0, dv_q[j-1].d})
                                       : tr[j-1][i][63:0];
        dv_d[j].ln[i].lo  = {dv_q[j-1].ln[i].lo[NS-2:0], ge[j-1][i]};
        dv_d[j].ln[i].big = dv_q[j-1].ln[i].big;
        dv_d[j].ln[i].neg = dv_q[j-1].ln[i].neg;
      end
    end
  end

  // Output: round, saturate, or pass the translation through when singular.
  se2cay_pkg::sat_t rs [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      rs[i] = se2cay_pkg::round_sat(dv_q[NS].ln[i]);
    end
    if (dv_q[NS].sing) begin
      oa_d = '0;
      ob_d = '0;
      ox_d = dv_q[NS].px;
      oy_d = dv_q[NS].py;
      of_d = 1'b1;
    end else begin
      oa_d = rs[0].val;
      ob_d = rs[1].val;
      ox_d = rs[2].val;
      oy_d = rs[3].val;
      of_d = rs[0].ovf || rs[1].ovf || rs[2].ovf || rs[3].ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      dv_vld_q  <= {dv_vld_q[NS-1:0], s3_vld_q};
      out_vld_q <= dv_vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      for (int j = 0; j <= NS; j++) begin
        dv_q[j] <= dv_d[j];
      end
      oa_q <= oa_d;
      ob_q <= ob_d;
      ox_q <= ox_d;
      oy_q <= oy_d;
      of_q <= of_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_a_o     = oa_q;
  assign out_b_o     = ob_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign flag_o      = of_q;

  // The first-stage and divider valid bits hold while the output beat is stalled.
  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(dv_vld_q) && $stable(s1_vld_q))
    else $error("pipeline moved during a stall");

  // A valid, non-singular beat whose lane 2 does not overflow leaves the divider with lane 2's remainder below divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld_q[NS] && !dv_q[NS].sing && !dv_q[NS].ln[2].big
      |-> dv_q[NS].ln[2].r < dv_q[NS].d)
    else $error("divider remainder out of range");

  // Singular results carry the flag and a zero out_a_o.
  a_sing_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && dv_vld_q[NS] && dv_q[NS].sing |=> flag_o && out_a_o == 32'sd0)
    else $error("singular beat not flagged");

endmodule
